@@ rtl/core/gpon_pkg.sv @@
// Package for the grid point owner node unit: widths, register indexes, divider step.
// No dependencies; used by gpon_dim and grid_point_owner_node_unit.
package gpon_pkg;

    localparam int COORD_BITS_DEF = 12;   // default saturation width of an owner
    localparam int PT_W           = 12;   // point, grid size, coarse size, owner field
    localparam int NODE_W         = 11;   // node count
    localparam int RAW_W          = 13;   // owner before saturation (remainder + quotient)
    localparam int DIV_STEP       = 4;    // quotient bits resolved per divider stage
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COARSE_X = 3'd0,
        CFG_COARSE_Y = 3'd1,
        CFG_COARSE_Z = 3'd2,
        CFG_NODES_X  = 3'd3,
        CFG_NODES_Y  = 3'd4,
        CFG_NODES_Z  = 3'd5
    } t_cfg_idx;

endpackage

@@ rtl/core/gpon_div.sv @@
// Pipelined restoring divider, STEP quotient bits per register stage, with a side payload.
// Depends on nothing; instantiated by gpon_dim.
module gpon_div #(
    parameter int NW   = 12,
    parameter int DW   = 12,
    parameter int PW   = 1,
    parameter int STEP = 4
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_pay
);
    localparam int STAGES = (NW + STEP - 1) / STEP;
    localparam int TOT    = STAGES * STEP;

    // numerator shifts out at the top while quotient bits shift in at the bottom
    logic [TOT-1:0] r_nq  [STAGES];
    logic [DW-1:0]  r_rem [STAGES];
    logic [DW-1:0]  r_den [STAGES];
    logic [PW-1:0]  r_pay [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [TOT-1:0] w_nq;
        logic [DW-1:0]  w_rem;
        logic [DW-1:0]  w_den;
        logic [PW-1:0]  w_pay;
        logic [TOT-1:0] n_nq;
        logic [DW-1:0]  n_rem;

        if (s == 0) begin : g_first
            assign w_nq  = TOT'(i_num);
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_pay = i_pay;
        end else begin : g_next
            assign w_nq  = r_nq[s-1];
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_pay = r_pay[s-1];
        end

        always_comb begin
            logic [DW:0] t;
            n_nq  = w_nq;
            n_rem = w_rem;
            for (int k = 0; k < STEP; k++) begin
                t    = {n_rem, n_nq[TOT-1]};
                n_nq = {n_nq[TOT-2:0], 1'b0};
                if (t >= {1'b0, w_den}) begin
                    t       = t - {1'b0, w_den};
                    n_nq[0] = 1'b1;
                end
                n_rem = t[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[s]  <= n_nq;
                r_rem[s] <= n_rem;
                r_den[s] <= w_den;
                r_pay[s] <= w_pay;
            end
        end
    end

    assign o_quo = r_nq[STAGES-1][NW-1:0];
    assign o_rem = r_rem[STAGES-1];
    assign o_pay = r_pay[STAGES-1];

endmodule

@@ rtl/core/gpon_dim.sv @@
// Owner lookup along one dimension: factor and block divides, block sizes, final divide.
// Depends on gpon_pkg and gpon_div.
module gpon_dim #(
    parameter int COORD_BITS = gpon_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [gpon_pkg::PT_W-1:0]   i_point,
    input  logic [gpon_pkg::PT_W-1:0]   i_grid,
    input  logic [gpon_pkg::PT_W-1:0]   i_coarse,
    input  logic [gpon_pkg::NODE_W-1:0] i_nodes,
    output logic [gpon_pkg::PT_W-1:0]   o_owner,
    output logic                        o_bad
);
    localparam int PW   = gpon_pkg::PT_W;
    localparam int NW_  = gpon_pkg::NODE_W;
    localparam int RW   = gpon_pkg::RAW_W;
    localparam int BW   = 2 * PW;          // factor * block
    localparam int SW   = PW + 1;          // block size clipped to 2**PW
    localparam int GW   = NW_ + SW;        // leading region size
    localparam logic [RW-1:0] LIM = (COORD_BITS >= RW) ? {RW{1'b1}}
                                                       : RW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [SW-1:0] CLIP = SW'(1) << PW;

    logic [PW-1:0]  w_fac, w_fac_pt, w_q0;
    logic [NW_-1:0] w_rem;
    logic           w_bad0;

    // factor = grid / coarse, point rides along
    gpon_div #(.NW(PW), .DW(PW), .PW(PW), .STEP(gpon_pkg::DIV_STEP)) u_div_fac (
        .i_clk (i_clk), .i_en (i_en),
        .i_num (i_grid), .i_den (i_coarse), .i_pay (i_point),
        .o_quo (w_fac), .o_rem (), .o_pay (w_fac_pt)
    );

    // coarse / nodes and coarse mod nodes
    gpon_div #(.NW(PW), .DW(NW_), .PW(1), .STEP(gpon_pkg::DIV_STEP)) u_div_blk (
        .i_clk (i_clk), .i_en (i_en),
        .i_num (i_coarse), .i_den (i_nodes),
        .i_pay (i_coarse == '0 || i_nodes == '0),
        .o_quo (w_q0), .o_rem (w_rem), .o_pay (w_bad0)
    );

    // stage M1: base block
    logic [BW-1:0]  r_base;
    logic [PW-1:0]  r_fac1, r_pt1;
    logic [NW_-1:0] r_rem1;
    logic           r_eq1, r_bad1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base <= BW'(w_fac) * BW'(w_q0);
            r_fac1 <= w_fac;
            r_pt1  <= w_fac_pt;
            r_rem1 <= w_rem;
            r_eq1  <= (w_rem == '0) || (w_fac == '0);
            r_bad1 <= w_bad0;
        end
    end

    // stage M2: larger block, both clipped, and leading region size
    logic [BW:0]    w_big;
    logic [SW-1:0]  w_big_s, w_base_s;
    logic [GW-1:0]  r_region;
    logic [SW-1:0]  r_big2, r_base2;
    logic [PW-1:0]  r_pt2;
    logic [NW_-1:0] r_rem2;
    logic           r_eq2, r_bad2;

    // no remainder: larger block is the base block itself
    assign w_big    = {1'b0, r_base} + (BW+1)'(r_eq1 ? {PW{1'b0}} : r_fac1);
    assign w_big_s  = (w_big  >= (BW+1)'(CLIP)) ? CLIP : w_big[SW-1:0];
    assign w_base_s = (r_base >= BW'(CLIP))     ? CLIP : r_base[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_region <= GW'(r_rem1) * GW'(w_big_s);
            r_big2   <= w_big_s;
            r_base2  <= w_base_s;
            r_pt2    <= r_pt1;
            r_rem2   <= r_rem1;
            r_eq2    <= r_eq1;
            r_bad2   <= r_bad1;
        end
    end

    // stage C: inside or past the leading region
    logic          w_lead;
    logic [PW-1:0] r_num3;
    logic [SW-1:0] r_den3;
    logic [PW-1:0] r_pay3;   // {bad, remainder to add}

    assign w_lead = r_eq2 || (GW'(r_pt2) < r_region);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num3 <= w_lead ? r_pt2 : r_pt2 - r_region[PW-1:0];
            r_den3 <= w_lead ? r_big2 : r_base2;
            r_pay3 <= {r_bad2 || (w_lead ? (r_big2 == '0) : (r_base2 == '0)),
                       w_lead ? {NW_{1'b0}} : r_rem2};
        end
    end

    logic [PW-1:0] w_quo, w_pay;
    logic [RW-1:0] w_raw;

    gpon_div #(.NW(PW), .DW(SW), .PW(PW), .STEP(gpon_pkg::DIV_STEP)) u_div_own (
        .i_clk (i_clk), .i_en (i_en),
        .i_num (r_num3), .i_den (r_den3), .i_pay (r_pay3),
        .o_quo (w_quo), .o_rem (), .o_pay (w_pay)
    );

    assign w_raw   = RW'(w_quo) + RW'(w_pay[NW_-1:0]);
    assign o_bad   = w_pay[PW-1];
    assign o_owner = (w_raw > LIM) ? LIM[PW-1:0] : w_raw[PW-1:0];

endmodule

@@ rtl/core/grid_point_owner_node_unit.sv @@
// Top level of the grid point owner node unit: stream ports, config registers, output stage.
// Depends on gpon_pkg and gpon_dim (which uses gpon_div).
//
//  channel   | direction | contents
//  s_axis    | in        | tdata: point_x/y/z, grid_size_x/y/z (12 b each)
//  m_axis    | out       | tdata: owner_x/y/z (12 b each); tuser: bad_setup
//  cfg write | in        | coarse_size_x/y/z (12 b), node_count_x/y/z (11 b)
//
// One transaction enters per cycle while the pipeline advances; each passes through two 3-stage
// dividers in series, two multiply stages, a select stage and the output register.
// The whole pipeline advances together whenever the output register is empty or
// being taken, so a downstream stall freezes every stage and loses nothing.
// Synchronous active-low reset clears the valid bits and sets the config registers to 1.
module grid_point_owner_node_unit #(
    parameter int COORD_BITS = gpon_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [71:0]                    s_axis_tdata,  // pt x,y,z, grid x,y,z
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // owner x,y,z, zero pad
    output logic                           m_axis_tuser,  // bad_setup
    input  logic                           i_cfg_we,
    input  logic [gpon_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gpon_pkg::PT_W-1:0]      i_cfg_wdata
);
    localparam int PW  = gpon_pkg::PT_W;
    localparam int NW_ = gpon_pkg::NODE_W;
    localparam int LAT = 3 * ((PW + gpon_pkg::DIV_STEP - 1) / gpon_pkg::DIV_STEP)
                         - ((PW + gpon_pkg::DIV_STEP - 1) / gpon_pkg::DIV_STEP) + 3;

    // config registers
    logic [PW-1:0]  r_coarse [3];
    logic [NW_-1:0] r_nodes  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < 3; d++) begin
                r_coarse[d] <= PW'(1);
                r_nodes[d]  <= NW_'(1);
            end
        end else if (i_cfg_we) begin
            case (gpon_pkg::t_cfg_idx'(i_cfg_idx))
                gpon_pkg::CFG_COARSE_X: r_coarse[0] <= i_cfg_wdata;
                gpon_pkg::CFG_COARSE_Y: r_coarse[1] <= i_cfg_wdata;
                gpon_pkg::CFG_COARSE_Z: r_coarse[2] <= i_cfg_wdata;
                gpon_pkg::CFG_NODES_X:  r_nodes[0]  <= i_cfg_wdata[NW_-1:0];
                gpon_pkg::CFG_NODES_Y:  r_nodes[1]  <= i_cfg_wdata[NW_-1:0];
                gpon_pkg::CFG_NODES_Z:  r_nodes[2]  <= i_cfg_wdata[NW_-1:0];
                default: ;
            endcase
        end
    end

    // global advance: output free or being taken
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // valid bits alongside the datapath stages
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    logic [PW-1:0] w_own [3];
    logic [2:0]    w_bad;

    for (genvar d = 0; d < 3; d++) begin : g_dim
        gpon_dim #(.COORD_BITS(COORD_BITS)) u_dim (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_point  (s_axis_tdata[d*PW +: PW]),
            .i_grid   (s_axis_tdata[(d+3)*PW +: PW]),
            .i_coarse (r_coarse[d]),
            .i_nodes  (r_nodes[d]),
            .o_owner  (w_own[d]),
            .o_bad    (w_bad[d])
        );
    end

    // output register; any bad dimension zeroes all owners
    logic          r_out_vld, r_out_bad;
    logic [PW-1:0] r_out_own [3];
    logic          w_any_bad;

    assign w_any_bad = |w_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_bad <= w_any_bad;
            for (int d = 0; d < 3; d++) begin
                r_out_own[d] <= w_any_bad ? '0 : w_own[d];
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0, r_out_own[2], r_out_own[1], r_out_own[0]};
    assign m_axis_tuser  = r_out_bad;

endmodule
